// ----- design/lcts_pkg.sv -----
// Shared types and constants for the load cell tare / calibrate / scale block.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package lcts_pkg;

  // Number of samples averaged for a tare and for a calibration (1 to 256).
  localparam int TARE_SAMPLES = 16;
  localparam int CAL_SAMPLES  = 16;

  localparam int TARE_LIM_I = (TARE_SAMPLES < 1) ? 1 : (TARE_SAMPLES > 256) ? 256 : TARE_SAMPLES;
  localparam int CAL_LIM_I  = (CAL_SAMPLES < 1) ? 1 : (CAL_SAMPLES > 256) ? 256 : CAL_SAMPLES;
  localparam logic [8:0] TARE_LIM = TARE_LIM_I[8:0];
  localparam logic [8:0] CAL_LIM  = CAL_LIM_I[8:0];

  localparam int CODE_W = 24;
  localparam int MEAS_W = 48;
  localparam int STAT_W = 3;
  localparam int SUM_W  = 34;
  localparam int CNT_W  = 9;
  localparam int FAC_W  = 32;
  localparam int DIVD_W = 40;  // dividend: weight shifted left by 16
  localparam int DIVS_W = 24;  // divisor: mean

  // Mean by reciprocal multiply: a full sum is below count * 2^24, so a shift of
  // 24 + 2 * clog2(count) with a rounded-up reciprocal gives the exact quotient.
  localparam int MEAN_IN_W = 32;  // sum bits that feed the mean
  localparam int RECIP_W   = 33;
  localparam int TARE_SH   = CODE_W + 2 * $clog2(TARE_LIM_I);
  localparam int CAL_SH    = CODE_W + 2 * $clog2(CAL_LIM_I);
  localparam logic [RECIP_W-1:0] TARE_RECIP =
    RECIP_W'(((64'd1 << TARE_SH) + 64'(TARE_LIM_I) - 64'd1) / 64'(TARE_LIM_I));
  localparam logic [RECIP_W-1:0] CAL_RECIP =
    RECIP_W'(((64'd1 << CAL_SH) + 64'(CAL_LIM_I) - 64'd1) / 64'(CAL_LIM_I));

  localparam logic [CODE_W-1:0] SIGN_FLIP  = 24'h800000;
  localparam logic [FAC_W-1:0]  UNITY_GAIN = 32'h0001_0000;

  // Mode register codes.
  localparam logic [1:0] MODE_MEASURE = 2'd0;
  localparam logic [1:0] MODE_TARE    = 2'd1;
  localparam logic [1:0] MODE_CAL     = 2'd2;

  // Register indexes on the configuration port.
  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_MEASURED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_COLLECTING = 3'd1;
  localparam logic [STAT_W-1:0] ST_TARE_DONE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_CAL_DONE   = 3'd3;
  localparam logic [STAT_W-1:0] ST_CAL_ERR    = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input code
    logic acc;       // add the sample into the running sum
    logic mul;       // register difference times factor
    logic meas_res;  // result: measurement
    logic coll_res;  // result: still collecting
    logic err_res;   // result: calibration error
    logic tare_upd;  // store mean as tare, result: tare done
    logic fac_upd;   // store factor, result: calibration done
    logic mean_ld;   // register the mean of the running sum
    logic div_fac;   // start divider: weight over mean
    logic clear;     // restart collection
    logic out_load;  // move the result into the output register
  } lcts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_tare;
    logic mode_cal;
    logic full;       // enough samples collected
    logic sum_nonpos; // sum is zero or negative
    logic div_done;
    logic mean_zero;
  } lcts_sts_t;

endpackage

`default_nettype wire

// ----- design/lcts_ifs.sv -----
// Valid/ready channel interfaces for converter words and results.
// Depends on lcts_pkg for field widths.
`default_nettype none

interface lcts_in_if;
  logic                        valid;
  logic                        ready;
  logic [lcts_pkg::CODE_W-1:0] adc_code;

  modport source (output valid, output adc_code, input ready);
  modport sink   (input valid, input adc_code, output ready);
endinterface

interface lcts_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lcts_pkg::MEAS_W-1:0] measurement;
  logic        [lcts_pkg::STAT_W-1:0] status;

  modport source (output valid, output measurement, output status, input ready);
  modport sink   (input valid, input measurement, input status, output ready);
endinterface

`default_nettype wire

// ----- design/load_cell_tare_calibrate_scale.sv -----
// Top level of the load cell tare / calibrate / scale block.
// Depends on lcts_pkg, lcts_ifs, lcts_ctrl and lcts_dp.
`default_nettype none

// Channel   Direction  Payload                              Transfer when
// in_ch     sink       adc_code[23:0]                       valid & ready
// out_ch    source     measurement[47:0] s, status[2:0]     valid & ready
// cfg_*     input      cfg_index (0 mode, 1 cal_weight),    cfg_we high
//                      cfg_wdata[23:0]
//
// A measurement, a sample still being collected or a calibration with a
// non-positive sum takes the shortest path; a sample that completes a tare
// or gives a zero mean adds one reciprocal multiply by the sample count, and
// one that completes a calibration adds a 40-step divide of weight by mean.
// One item is in flight at a time; in_ch.ready is high only while the controller
// is idle, and a result waiting in the output register lets the next item in.
// Reset is synchronous and active low.

module load_cell_tare_calibrate_scale (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  lcts_in_if.sink                           in_ch,
  lcts_out_if.source                        out_ch,
  input  wire logic                         cfg_we,
  input  wire logic                         cfg_index,
  input  wire logic [lcts_pkg::CODE_W-1:0]  cfg_wdata
);

  lcts_pkg::lcts_cmd_t cmd;
  lcts_pkg::lcts_sts_t sts;
  logic                in_ready;
  logic                out_valid;

  // Controller: sequences the steps of each item and the two handshakes.
  lcts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: registers, multipliers, divider and result/output registers.
  lcts_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_code    (in_ch.adc_code),
    .cmd        (cmd),
    .sts        (sts),
    .out_meas   (out_ch.measurement),
    .out_status (out_ch.status)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

// ----- design/lcts_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lcts_pkg for operand widths.
`default_nettype none

module lcts_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lcts_pkg::DIVD_W-1:0]   dividend,
  input  wire logic [lcts_pkg::DIVS_W-1:0]   divisor,
  output logic                               done,
  output logic [lcts_pkg::DIVD_W-1:0]        quotient
);

  localparam int STEP_W = $clog2(lcts_pkg::DIVD_W + 1);
  localparam logic [STEP_W-1:0] STEPS = lcts_pkg::DIVD_W[STEP_W-1:0];

  logic [STEP_W-1:0]              cnt_r, cnt_nxt;
  logic                           done_r, done_nxt;
  logic [lcts_pkg::DIVS_W-1:0]    rem_r, rem_nxt;
  logic [lcts_pkg::DIVD_W-1:0]    quo_r, quo_nxt;
  logic [lcts_pkg::DIVS_W-1:0]    dvs_r, dvs_nxt;
  logic [lcts_pkg::DIVS_W:0]      shifted;
  logic [lcts_pkg::DIVS_W:0]      trial;
  logic                           ge;

  assign shifted = {rem_r, quo_r[lcts_pkg::DIVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_comb begin
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = STEPS;
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - 1'b1;
      rem_nxt  = ge ? trial[lcts_pkg::DIVS_W-1:0] : shifted[lcts_pkg::DIVS_W-1:0];
      quo_nxt  = {quo_r[lcts_pkg::DIVD_W-2:0], ge};
      done_nxt = (cnt_r == {{(STEP_W-1){1'b0}}, 1'b1});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ----- design/lcts_dp.sv -----
// Datapath: configuration registers, tare, factor, running sum, multipliers,
// divider and result registers. Depends on lcts_pkg and lcts_div.
`default_nettype none

module lcts_dp (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [lcts_pkg::CODE_W-1:0]        cfg_wdata,
  input  wire logic [lcts_pkg::CODE_W-1:0]        in_code,
  input  wire lcts_pkg::lcts_cmd_t                cmd,
  output lcts_pkg::lcts_sts_t                     sts,
  output logic signed [lcts_pkg::MEAS_W-1:0]      out_meas,
  output logic        [lcts_pkg::STAT_W-1:0]      out_status
);

  localparam int PROD_W = lcts_pkg::CODE_W + 1 + lcts_pkg::FAC_W + 1;

  logic [1:0]                          mode_r;
  logic [lcts_pkg::CODE_W-1:0]         weight_r;
  logic [lcts_pkg::CODE_W-1:0]         tare_r;
  logic [lcts_pkg::FAC_W-1:0]          factor_r;
  logic signed [lcts_pkg::SUM_W-1:0]   sum_r;
  logic [lcts_pkg::CNT_W-1:0]          cnt_r;
  logic [lcts_pkg::CODE_W-1:0]         code_r;
  logic signed [PROD_W-1:0]            prod_r;
  logic [lcts_pkg::DIVS_W-1:0]         mean_r;
  logic signed [lcts_pkg::MEAS_W-1:0]  res_meas_r;
  logic [lcts_pkg::STAT_W-1:0]         res_stat_r;
  logic signed [lcts_pkg::MEAS_W-1:0]  out_meas_r;
  logic [lcts_pkg::STAT_W-1:0]         out_stat_r;

  logic signed [lcts_pkg::CODE_W:0]    diff;
  logic signed [lcts_pkg::SUM_W-1:0]   sample;
  logic                                mode_tare;
  logic                                mode_cal;
  logic                                div_start;
  logic [lcts_pkg::DIVD_W-1:0]         div_dvd;
  logic [lcts_pkg::DIVS_W-1:0]         div_dvs;
  logic                                div_done;
  logic [lcts_pkg::DIVD_W-1:0]         div_quo;
  logic [lcts_pkg::FAC_W-1:0]          fac_sat;
  logic [lcts_pkg::CNT_W-1:0]          lim;
  logic [lcts_pkg::RECIP_W-1:0]        recip;
  logic [lcts_pkg::MEAN_IN_W+lcts_pkg::RECIP_W-1:0] mean_prod;
  logic [lcts_pkg::DIVS_W-1:0]         mean_val;

  assign mode_tare = (mode_r == lcts_pkg::MODE_TARE);
  assign mode_cal  = (mode_r == lcts_pkg::MODE_CAL);
  assign lim       = mode_tare ? lcts_pkg::TARE_LIM : lcts_pkg::CAL_LIM;

  assign diff   = $signed({1'b0, code_r}) - $signed({1'b0, tare_r});
  assign sample = mode_tare ? $signed({{(lcts_pkg::SUM_W-lcts_pkg::CODE_W){1'b0}}, code_r})
                            : {{(lcts_pkg::SUM_W-lcts_pkg::CODE_W-1){diff[lcts_pkg::CODE_W]}},
                               diff};

  // Mean of a full, non-negative sum: multiply by the reciprocal of the count.
  assign recip     = mode_tare ? lcts_pkg::TARE_RECIP : lcts_pkg::CAL_RECIP;
  assign mean_prod = sum_r[lcts_pkg::MEAN_IN_W-1:0] * recip;
  assign mean_val  = mode_tare ? mean_prod[lcts_pkg::TARE_SH +: lcts_pkg::DIVS_W]
                               : mean_prod[lcts_pkg::CAL_SH +: lcts_pkg::DIVS_W];

  // Divider operands: the weight over the mean.
  assign div_start = cmd.div_fac;
  assign div_dvd   = {weight_r, 16'h0000};
  assign div_dvs   = mean_r;

  assign fac_sat = (div_quo[lcts_pkg::DIVD_W-1:lcts_pkg::FAC_W] != '0) ? '1
                   : div_quo[lcts_pkg::FAC_W-1:0];

  lcts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= lcts_pkg::MODE_MEASURE;
      weight_r <= '0;
      tare_r   <= '0;
      factor_r <= lcts_pkg::UNITY_GAIN;
      sum_r    <= '0;
      cnt_r    <= '0;
    end else begin
      if (cfg_we && cfg_index == lcts_pkg::REG_WEIGHT) begin
        weight_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == lcts_pkg::REG_MODE) begin
        mode_r <= cfg_wdata[1:0];
        sum_r  <= '0;
        cnt_r  <= '0;
      end else if (cmd.clear) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else if (cmd.acc) begin
        sum_r <= sum_r + sample;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.tare_upd) begin
        tare_r <= mean_r;
      end
      if (cmd.fac_upd) begin
        factor_r <= fac_sat;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r <= in_code ^ lcts_pkg::SIGN_FLIP;
    end
    if (cmd.mul) begin
      prod_r <= diff * $signed({1'b0, factor_r});
    end
    if (cmd.mean_ld) begin
      mean_r <= mean_val;
    end
    if (cmd.meas_res) begin
      // arithmetic shift gives the floor of the Q16 product
      res_meas_r <= {{(lcts_pkg::MEAS_W-(PROD_W-16)){prod_r[PROD_W-1]}}, prod_r[PROD_W-1:16]};
      res_stat_r <= lcts_pkg::ST_MEASURED;
    end else if (cmd.coll_res) begin
      res_meas_r <= '0;
      res_stat_r <= lcts_pkg::ST_COLLECTING;
    end else if (cmd.err_res) begin
      res_meas_r <= '0;
      res_stat_r <= lcts_pkg::ST_CAL_ERR;
    end else if (cmd.tare_upd) begin
      res_meas_r <= '0;
      res_stat_r <= lcts_pkg::ST_TARE_DONE;
    end else if (cmd.fac_upd) begin
      res_meas_r <= '0;
      res_stat_r <= lcts_pkg::ST_CAL_DONE;
    end
    if (cmd.out_load) begin
      out_meas_r <= res_meas_r;
      out_stat_r <= res_stat_r;
    end
  end

  assign sts.mode_tare  = mode_tare;
  assign sts.mode_cal   = mode_cal;
  assign sts.full       = (cnt_r >= lim);
  assign sts.sum_nonpos = sum_r[lcts_pkg::SUM_W-1] | (sum_r == '0);
  assign sts.div_done   = div_done;
  assign sts.mean_zero  = (mean_r == '0);

  assign out_meas   = out_meas_r;
  assign out_status = out_stat_r;

endmodule

`default_nettype wire

// ----- design/lcts_ctrl.sv -----
// Controller: sequences one item through accumulate, multiply or divide steps
// and owns the handshakes. Depends on lcts_pkg for command and status structs.
`default_nettype none

module lcts_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire lcts_pkg::lcts_sts_t  sts,
  output lcts_pkg::lcts_cmd_t       cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EXEC = 7'b0000010,
    S_MEAS = 7'b0000100,
    S_FIN  = 7'b0001000,
    S_MEAN = 7'b0010000,
    S_DIVF = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.mode_tare || sts.mode_cal) begin
          cmd.acc   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_MEAS;
        end
      end
      S_MEAS: begin
        cmd.meas_res = 1'b1;
        state_nxt    = S_DONE;
      end
      S_FIN: begin
        if (!sts.full) begin
          cmd.coll_res = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.mode_cal && sts.sum_nonpos) begin
          cmd.err_res = 1'b1;
          cmd.clear   = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.mean_ld = 1'b1;
          state_nxt   = S_MEAN;
        end
      end
      S_MEAN: begin
        if (sts.mode_tare) begin
          cmd.tare_upd = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_DONE;
        end else if (sts.mean_zero) begin
          cmd.err_res = 1'b1;
          cmd.clear   = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.div_fac = 1'b1;
          state_nxt   = S_DIVF;
        end
      end
      S_DIVF: begin
        if (sts.div_done) begin
          cmd.fac_upd = 1'b1;
          cmd.clear   = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- design/lcts_chk.sv -----
// Port-level checker for the load cell block, attached by bind.
// Depends on lcts_pkg for status codes.
`default_nettype none

module lcts_chk (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [lcts_pkg::MEAS_W-1:0]  out_meas,
  input wire logic        [lcts_pkg::STAT_W-1:0]  out_status
);

  // Drop any pending result on reset.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Hold a stalled result.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_meas) && $stable(out_status))
    else $error("stalled result changed");

  // One item in flight: no transfer in the cycle after one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // Non-measurement results carry a zero measurement.
  a_zero_meas: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != lcts_pkg::ST_MEASURED |-> out_meas == '0)
    else $error("nonzero measurement on non-measure result");

  // Status code stays within the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= lcts_pkg::ST_CAL_ERR)
    else $error("undefined status code");

endmodule

bind load_cell_tare_calibrate_scale lcts_chk u_lcts_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_meas   (out_ch.measurement),
  .out_status (out_ch.status)
);

`default_nettype wire

// ----- tb/sv/tb_load_cell_tare_calibrate_scale.sv -----
// Self-checking testbench for the load cell tare / calibrate / scale block.
// Depends on lcts_pkg, the lcts_in_if / lcts_out_if channels and the block's RTL.
`default_nettype none

module tb_load_cell_tare_calibrate_scale;
  timeunit 1ns;
  timeprecision 1ps;

  import lcts_pkg::*;

  // Cap on the whole run. The slowest correct run (every item a calibration
  // completion, full sender gaps and sink stalls, a settle per phase) stays
  // well under a third of this.
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int QUIET_AFTER   = 1700;
  localparam int SHOWN_ERRORS  = 10;
  localparam int TAIL_CYCLES   = 100;
  localparam longint MEAS_MAX  = 64'sd140737488355327;
  localparam longint MEAS_MIN  = -64'sd140737488355328;

  // One result as it leaves the block.
  typedef struct packed {
    logic signed [MEAS_W-1:0] meas;
    logic        [STAT_W-1:0] st;
  } reading_t;

  // Rows of the directed table: a converter word, or a register write.
  typedef enum logic [1:0] {ROW_WORD, ROW_MODE, ROW_WEIGHT} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic        [CODE_W-1:0] data;
    logic                     typed;  // expected result given in the row
    logic signed [MEAS_W-1:0] meas;
    logic        [STAT_W-1:0] st;
  } plan_row_t;

  typedef enum int {
    RUN_MEASURE, RUN_TARE, RUN_CAL, RUN_CAL_REJECT, RUN_CAL_CLIP, RUN_RESTART,
    RUN_WEIGHT_SWAP
  } run_kind_t;

  localparam int PLAN_ROWS = 23;

  // After reset: tare 0 and unity gain, so a measurement is the offset code.
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    '{ROW_WORD,   24'h800000, 1'b1, 48'sd0,        ST_MEASURED},   // zero code
    '{ROW_WORD,   24'h7FFFFF, 1'b1, 48'sd16777215, ST_MEASURED},   // full scale
    '{ROW_WORD,   24'h000000, 1'b1, 48'sd8388608,  ST_MEASURED},
    '{ROW_WORD,   24'hFFFFFF, 1'b1, 48'sd8388607,  ST_MEASURED},
    '{ROW_WORD,   24'hAAAAAA, 1'b1, 48'sd2796202,  ST_MEASURED},
    '{ROW_WORD,   24'h555555, 1'b1, 48'sd13981013, ST_MEASURED},
    '{ROW_MODE,   24'h000001, 1'b0, 48'sd0,        ST_MEASURED},
    '{ROW_WORD,   24'h123456, 1'b1, 48'sd0,        ST_COLLECTING},
    '{ROW_WORD,   24'hFEDCBA, 1'b1, 48'sd0,        ST_COLLECTING},
    '{ROW_WORD,   24'h000000, 1'b1, 48'sd0,        ST_COLLECTING},
    // a mode write abandons the partial tare; the tare stays zero
    '{ROW_MODE,   24'h000000, 1'b0, 48'sd0,        ST_MEASURED},
    '{ROW_WORD,   24'h800001, 1'b1, 48'sd1,        ST_MEASURED},
    '{ROW_WEIGHT, 24'hFFFFFF, 1'b0, 48'sd0,        ST_MEASURED},
    '{ROW_MODE,   24'h000002, 1'b0, 48'sd0,        ST_MEASURED},
    '{ROW_WORD,   24'h000000, 1'b1, 48'sd0,        ST_COLLECTING},
    '{ROW_WORD,   24'hFFFFFF, 1'b1, 48'sd0,        ST_COLLECTING},
    // undefined mode 3 (upper data bits ignored) measures
    '{ROW_MODE,   24'hFFFFFF, 1'b0, 48'sd0,        ST_MEASURED},
    '{ROW_WORD,   24'h7FFFFF, 1'b1, 48'sd16777215, ST_MEASURED},
    '{ROW_WORD,   24'h800000, 1'b1, 48'sd0,        ST_MEASURED},
    '{ROW_MODE,   24'hFFFFFE, 1'b0, 48'sd0,        ST_MEASURED},
    '{ROW_WORD,   24'h7FFFFF, 1'b1, 48'sd0,        ST_COLLECTING},
    '{ROW_MODE,   24'h000000, 1'b0, 48'sd0,        ST_MEASURED},
    '{ROW_WEIGHT, 24'h000000, 1'b0, 48'sd0,        ST_MEASURED}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [CODE_W-1:0] cfg_wdata;

  lcts_in_if  in_ch ();
  lcts_out_if out_ch ();

  load_cell_tare_calibrate_scale uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the block's registers and state.
  logic [1:0]        scale_mode;
  logic [CODE_W-1:0] ref_weight;
  logic [CODE_W-1:0] tare_mirror;
  logic [FAC_W-1:0]  gain_mirror;
  longint            running_sum;
  int                samples_held;

  reading_t pending_readings [$];

  int  items_sent;
  int  readings_seen;
  int  fail_count;
  int  tare_runs;
  int  cal_runs;
  int  cal_rejects;
  int  gain_clips;
  bit  quiet;          // no idling on either side
  bit  send_gaps_on;
  bit  sink_stalls_on;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Work out the result of one accepted converter word and advance the mirror.
  task automatic predict_reading(input logic [CODE_W-1:0] word, output reading_t r);
    logic [CODE_W-1:0] code;
    longint code_l;
    longint tare_l;
    longint gain_l;
    longint diff;
    longint scaled;
    longint mean;
    longint quot;
    longint weight_l;
    begin
      code   = word ^ SIGN_FLIP;
      code_l = code;
      tare_l = tare_mirror;
      gain_l = gain_mirror;
      diff   = code_l - tare_l;
      r.meas = '0;
      if (scale_mode == MODE_TARE) begin
        running_sum += code_l;
        samples_held++;
        if (samples_held >= TARE_LIM_I) begin
          tare_mirror  = CODE_W'(running_sum / TARE_LIM_I);
          running_sum  = 0;
          samples_held = 0;
          r.st = ST_TARE_DONE;
          tare_runs++;
        end else begin
          r.st = ST_COLLECTING;
        end
      end else if (scale_mode == MODE_CAL) begin
        running_sum += diff;
        samples_held++;
        if (samples_held >= CAL_LIM_I) begin
          // signed division truncates toward zero
          mean = running_sum / CAL_LIM_I;
          if (mean <= 0) begin
            r.st = ST_CAL_ERR;
            cal_rejects++;
          end else begin
            weight_l = ref_weight;
            quot = (weight_l << 16) / mean;
            if (quot > 64'sh0_FFFF_FFFF) begin
              gain_mirror = '1;
              gain_clips++;
            end else begin
              gain_mirror = FAC_W'(quot);
            end
            r.st = ST_CAL_DONE;
          end
          running_sum  = 0;
          samples_held = 0;
          cal_runs++;
        end else begin
          r.st = ST_COLLECTING;
        end
      end else begin
        // measure, and undefined mode 3: arithmetic shift floors the quotient
        scaled = (diff * gain_l) >>> 16;
        if (scaled > MEAS_MAX) scaled = MEAS_MAX;
        if (scaled < MEAS_MIN) scaled = MEAS_MIN;
        r.meas = MEAS_W'(scaled);
        r.st   = ST_MEASURED;
      end
    end
  endtask

  // Offer one converter word; valid stays high after the transfer so a
  // following word can go out back to back.
  task automatic send_word(input logic [CODE_W-1:0] word, input bit typed,
                           input reading_t typed_result);
    reading_t r;
    begin
      if (!quiet && send_gaps_on && $urandom_range(0, 3) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      in_ch.valid    <= 1'b1;
      in_ch.adc_code <= word;
      do @(posedge clk); while (!in_ch.ready);
      predict_reading(word, r);
      pending_readings.push_back(typed ? typed_result : r);
      items_sent++;
    end
  endtask

  // Hold the sender until every result is back, then let the block settle.
  task automatic drain_block();
    begin
      in_ch.valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
    end
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic idx, input logic [CODE_W-1:0] data);
    begin
      drain_block();
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= data;
      @(posedge clk);
      cfg_we <= 1'b0;
      if (idx == REG_MODE) begin
        scale_mode   = data[1:0];
        running_sum  = 0;
        samples_held = 0;
      end else begin
        ref_weight = data;
      end
      @(posedge clk);
    end
  endtask

  // Mode write with random upper data bits, which the block drops.
  task automatic set_mode(input logic [1:0] m);
    begin
      write_reg(REG_MODE, {22'($urandom_range(0, 24'h3FFFFF)), m});
    end
  endtask

  // Feed samples clustered around a code; spread 0 repeats the code exactly.
  task automatic feed_cluster(input logic [CODE_W-1:0] center, input int spread,
                              input int count);
    int noise;
    begin
      for (int k = 0; k < count; k++) begin
        noise = (spread == 0) ? 0 : $urandom_range(0, 2 * spread) - spread;
        send_word((center + CODE_W'(noise)) ^ SIGN_FLIP, 1'b0, '0);
      end
    end
  endtask

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      readings_seen++;
      if (pending_readings.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_ERRORS)
          $display("unexpected result: meas %0d status %0d", out_ch.measurement,
                   out_ch.status);
      end else begin
        want = pending_readings.pop_front();
        if (out_ch.measurement !== want.meas || out_ch.status !== want.st) begin
          fail_count++;
          if (fail_count <= SHOWN_ERRORS)
            $display("result %0d: expected meas %0d status %0d, got meas %0d status %0d",
                     readings_seen, want.meas, want.st, out_ch.measurement,
                     out_ch.status);
        end
      end
    end
  end

  // Result sink: random stall bursts, none once the run goes quiet.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!quiet && sink_stalls_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout with %0d results outstanding", pending_readings.size());
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    run_kind_t kind;
    int        phase;
    int        extra;
    int        delta;
    logic [CODE_W-1:0] center;

    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_MODE;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.adc_code <= '0;
    scale_mode     = MODE_MEASURE;
    ref_weight     = '0;
    tare_mirror    = '0;
    gain_mirror    = UNITY_GAIN;
    running_sum    = 0;
    samples_held   = 0;
    items_sent     = 0;
    readings_seen  = 0;
    fail_count     = 0;
    tare_runs      = 0;
    cal_runs       = 0;
    cal_rejects    = 0;
    gain_clips     = 0;
    quiet          = 1'b0;
    send_gaps_on   = 1'b1;
    sink_stalls_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: extremes after reset, partial collections, mode 3.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (DIRECTED_PLAN[i].kind)
        ROW_MODE:   write_reg(REG_MODE, DIRECTED_PLAN[i].data);
        ROW_WEIGHT: write_reg(REG_WEIGHT, DIRECTED_PLAN[i].data);
        default: begin
          send_word(DIRECTED_PLAN[i].data, DIRECTED_PLAN[i].typed,
                    '{meas: DIRECTED_PLAN[i].meas, st: DIRECTED_PLAN[i].st});
        end
      endcase
    end

    // Random phases: the first pass walks every kind once, then pick freely.
    phase = 0;
    while (items_sent < PLAN_ROWS + RANDOM_ITEMS) begin
      kind = (phase < 7) ? run_kind_t'(phase) : run_kind_t'($urandom_range(0, 6));
      phase++;
      quiet          = (items_sent >= QUIET_AFTER);
      send_gaps_on   = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      case (kind)
        RUN_MEASURE: begin
          // mode 0 mostly, undefined mode 3 now and then
          set_mode(($urandom_range(0, 3) == 0) ? 2'd3 : MODE_MEASURE);
          repeat ($urandom_range(5, 40)) begin
            case ($urandom_range(0, 3))
              0:       feed_cluster(tare_mirror, 300, 1);
              1:       send_word(($urandom_range(0, 1) != 0) ? 24'h7FFFFF : 24'h800000,
                                 1'b0, '0);
              default: send_word(CODE_W'($urandom), 1'b0, '0);
            endcase
          end
        end
        RUN_TARE: begin
          set_mode(MODE_TARE);
          case ($urandom_range(0, 3))
            0:       center = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
            default: center = CODE_W'($urandom);
          endcase
          repeat ($urandom_range(1, 2))
            feed_cluster(center, $urandom_range(0, 3) == 0 ? 0 : 5000, TARE_LIM_I);
          // a few leftover samples that the next mode write throws away
          feed_cluster(center, 100, $urandom_range(0, 3));
        end
        RUN_CAL, RUN_CAL_REJECT, RUN_CAL_CLIP: begin
          case (kind)
            RUN_CAL_CLIP: write_reg(REG_WEIGHT,
                                    CODE_W'($urandom_range(65536, 24'hFFFFFF)));
            default: begin
              case ($urandom_range(0, 4))
                0:       write_reg(REG_WEIGHT, 24'h000000);
                1:       write_reg(REG_WEIGHT, 24'hFFFFFF);
                default: write_reg(REG_WEIGHT, CODE_W'($urandom));
              endcase
            end
          endcase
          set_mode(MODE_CAL);
          repeat ($urandom_range(1, 2)) begin
            case (kind)
              RUN_CAL_REJECT: begin
                // zero, slightly positive (mean truncates to 0) or negative load
                for (int k = 0; k < CAL_LIM_I; k++) begin
                  delta = $urandom_range(0, 30) - 20;
                  feed_cluster(tare_mirror + CODE_W'(delta), 0, 1);
                end
              end
              RUN_CAL_CLIP: feed_cluster(tare_mirror + CODE_W'($urandom_range(1, 3)), 0,
                                         CAL_LIM_I);
              default: begin
                delta = $urandom_range(1, 1 << 22);
                feed_cluster(tare_mirror + CODE_W'(delta), delta / 8, CAL_LIM_I);
              end
            endcase
          end
          // measure with the new gain
          set_mode(MODE_MEASURE);
          repeat ($urandom_range(3, 12)) feed_cluster(tare_mirror, 1 << 20, 1);
        end
        RUN_RESTART: begin
          // abandon a partial average by rewriting the same mode, then finish one
          center = CODE_W'($urandom);
          if ($urandom_range(0, 1) != 0) begin
            set_mode(MODE_TARE);
            feed_cluster(center, 2000, $urandom_range(1, TARE_LIM_I - 1));
            set_mode(MODE_TARE);
            feed_cluster(center + 24'h10000, 2000, TARE_LIM_I);
          end else begin
            set_mode(MODE_CAL);
            feed_cluster(tare_mirror - 24'd5000, 100, $urandom_range(1, CAL_LIM_I - 1));
            set_mode(MODE_CAL);
            feed_cluster(tare_mirror + 24'd5000, 100, CAL_LIM_I);
          end
        end
        default: begin
          // weight changes mid-average; the collection keeps going
          set_mode(MODE_CAL);
          delta = $urandom_range(1, 1 << 16);
          feed_cluster(tare_mirror + CODE_W'(delta), 50, CAL_LIM_I / 2);
          write_reg(REG_WEIGHT, CODE_W'($urandom));
          feed_cluster(tare_mirror + CODE_W'(delta), 50, CAL_LIM_I - CAL_LIM_I / 2);
        end
      endcase
    end

    // Drop valid, wait out every result, then a quiet tail.
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d converter words in %0d phases, checked %0d results",
             items_sent, phase, readings_seen);
    $display("completed %0d tare averages and %0d calibrations (%0d rejected, %0d gain clipped)",
             tare_runs, cal_runs, cal_rejects, gain_clips);
    if (fail_count == 0 && pending_readings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
